/* src/cla_pkg.sv */
// ============================================================================
// cla_pkg: shared types and constants for the command line assembler
// Character codes, line end modes, register map and the result record.
// ============================================================================
package cla_pkg;

    // Control characters
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_DEL  = 8'h7F;

    // Line end selection
    typedef enum logic [1:0] {
        TERM_NUL     = 2'd0,
        TERM_CR      = 2'd1,
        TERM_LF_DATA = 2'd2,
        TERM_CR_LF   = 2'd3
    } eol_sel_t;

    localparam eol_sel_t EOL_SEL_RESET = TERM_CR;

    // Register map: byte address 4*i, word index in paddr[2]
    localparam int         APB_ADDR_W  = 3;
    localparam logic       REG_EOL_SEL = 1'b0;

    // One result, last field in the lowest bits
    typedef struct packed {
        logic [8:0] line_length;
        logic       line_done;
        logic       dropped;
        logic [7:0] store_value;
        logic [7:0] store_index;
        logic       store_valid;
    } cla_result_t;

    localparam int RESULT_W = $bits(cla_result_t);

endpackage

/* src/cla_apb_regs.sv */
// ============================================================================
// cla_apb_regs: configuration register file
// APB slave holding the line end mode; zero wait states.
// ============================================================================
module cla_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cla_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output cla_pkg::eol_sel_t                   eol_sel
);
    import cla_pkg::*;

    eol_sel_t   eol_sel_reg;
    eol_sel_t   eol_sel_next;
    logic       wr_en;
    logic       sel_eol;

    assign pready  = 1'b1;
    assign sel_eol = (paddr[2] == REG_EOL_SEL);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        eol_sel_next = eol_sel_reg;
        if (wr_en && sel_eol)
        begin
            eol_sel_next = eol_sel_t'(pwdata[1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eol_sel_reg <= EOL_SEL_RESET;
        end
        else
        begin
            eol_sel_reg <= eol_sel_next;
        end
    end

    // Unmapped words read as zero
    assign prdata  = sel_eol ? {30'd0, eol_sel_reg} : 32'd0;
    assign eol_sel = eol_sel_reg;

endmodule

/* src/cla_out_buf.sv */
// ============================================================================
// cla_out_buf: two-entry result buffer
// Output register plus skid entry, so the input takes one more result under a stall.
// ============================================================================
module cla_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cla_pkg::cla_result_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cla_pkg::cla_result_t  out_data
);
    import cla_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    cla_result_t out_data_reg;
    cla_result_t out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    cla_result_t skid_data_reg;
    cla_result_t skid_data_next;
    logic        in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            // Output slot frees up: refill from skid first, else from input
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end
        else if (in_fire)
        begin
            // Output held: park the new result
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* src/command_line_assembler.sv */
// ============================================================================
// command_line_assembler: command line buffer with backspace and line end
// Assembles received bytes into a line buffer memory and reports line ends.
// ============================================================================
// Each accepted byte yields exactly one result on the master stream; a new
// byte is taken every cycle, and a two-entry output buffer keeps bytes flowing
// for one extra result while the master side stalls, then input waits. Printable
// and other bytes are written at the current line position; backspace (0x08)
// and DEL (0x7F) clear the previous slot and shorten the line, stopping at
// zero. A double quote toggles an in-quotes flag that masks line end
// detection. Past LINE_DEPTH bytes, input is dropped and flagged. The line end
// is chosen by the eol_sel register: NUL, CR, LF after a nonzero byte, or CR
// then LF; an LF at position zero never ends a line. On a line end the result
// carries the length including the terminator and the line restarts at zero.
// The last stored byte is kept in a register; after a backspace it is fetched
// from the buffer memory's registered read port in the same cycle the
// backspace is taken, so the lookback is ready for the very next byte. The
// buffer holds no reset value and needs no clearing pass: only slots below the
// current length are ever looked at.
// ============================================================================
module command_line_assembler #(
    parameter int LINE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] store_valid, [8:1] store_index,
                                        // [16:9] store_value, [17] dropped,
                                        // [18] line_done, [27:19] line_length,
                                        // [31:28] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cla_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    eol_sel_t eol_sel;

    cla_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .eol_sel   (eol_sel)
    );

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          quotes_reg;
    logic          quotes_next;
    logic [7:0]    prev_reg;          // last stored byte when not from memory
    logic [7:0]    prev_next;
    logic          prev_mem_reg;      // lookback sits in the memory read data
    logic          prev_mem_next;

    // Line buffer memory, one write and one read port
    logic [7:0]    line_mem [LINE_DEPTH];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    // Step logic
    logic          in_fire;
    logic [7:0]    ch;
    logic          is_erase;
    logic          is_quote;
    logic          full;
    logic [CW-1:0] pos;
    logic [CW-1:0] count_step;
    logic          store;
    logic          has_prev;
    logic [7:0]    prev_byte;
    logic          term_hit;
    logic          done;
    cla_result_t   res;
    cla_result_t   out_res;
    logic          res_ready;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign ch       = s_axis_tdata;
    assign is_erase = (ch == CH_BS) || (ch == CH_DEL);
    assign is_quote = (ch == CH_QUOT);
    assign full     = (count_reg == DEPTH_C);

    always_comb
    begin
        // Erase steps back one slot, never below zero
        if (is_erase)
        begin
            pos        = (count_reg != '0) ? count_reg - CW'(1) : '0;
            count_step = pos;
        end
        else
        begin
            pos        = count_reg;
            count_step = full ? count_reg : count_reg + CW'(1);
        end
    end

    assign store       = is_erase || !full;
    assign quotes_next = in_fire ? (quotes_reg ^ (is_quote && !is_erase)) : quotes_reg;
    assign has_prev    = (pos != '0);
    assign prev_byte   = prev_mem_reg ? mem_rdata_reg : prev_reg;

    always_comb
    begin
        case (eol_sel)
            TERM_NUL:     term_hit = (ch == CH_NUL);
            TERM_CR:      term_hit = (ch == CH_CR);
            TERM_LF_DATA: term_hit = has_prev && (prev_byte != CH_NUL) && (ch == CH_LF);
            TERM_CR_LF:   term_hit = has_prev && (prev_byte == CH_CR) && (ch == CH_LF);
            default:      term_hit = 1'b0;
        endcase
    end

    // Dropped bytes skip line end detection
    assign done = store && !quotes_next && term_hit;

    always_comb
    begin
        res             = '0;
        res.store_valid = store;
        res.store_index = store ? 8'(pos) : 8'd0;
        res.store_value = (store && !is_erase) ? ch : 8'd0;
        res.dropped     = !store;
        res.line_done   = done;
        res.line_length = done ? 9'(count_step) : 9'd0;
    end

    // Memory accesses: write the slot, and after an erase fetch the new
    // last byte (two below the old count) for the next lookback
    assign mem_we    = in_fire && store;
    assign mem_waddr = AW'(pos);
    assign mem_wdata = res.store_value;
    assign mem_re    = in_fire && is_erase;
    assign mem_raddr = AW'(count_reg - CW'(2));

    always_comb
    begin
        count_next    = count_reg;
        prev_next     = prev_reg;
        prev_mem_next = prev_mem_reg;
        if (in_fire)
        begin
            count_next = done ? '0 : count_step;
            if (is_erase)
            begin
                prev_mem_next = 1'b1;
            end
            else if (store)
            begin
                // Forward the byte just written
                prev_next     = ch;
                prev_mem_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            quotes_reg   <= 1'b0;
            prev_mem_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            quotes_reg   <= quotes_next;
            prev_mem_reg <= prev_mem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= line_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------
    cla_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign s_axis_tready = res_ready;
    assign m_axis_tdata  = {(32 - RESULT_W)'(0), out_res};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("line count beyond buffer depth");

    a_drop_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_res.dropped |-> !out_res.store_valid && !out_res.line_done)
        else $error("dropped byte reported as stored or ending a line");

    a_len_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_res.line_done |-> out_res.line_length == 9'd0)
        else $error("line length without line end");

    a_erase_lookback: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_erase |=> prev_mem_reg)
        else $error("erase did not switch lookback to memory");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule
